>>> rtl/core/ibni_pkg.sv
// Shared constants, types and command/status structs for the IMU bias and noise injector.
`default_nettype none
package ibni_pkg;

  localparam int unsigned NUM_AXES   = 6;
  localparam int unsigned AXIS_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SIGMA_W    = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned STEPS      = 2 * NUM_AXES;
  localparam int unsigned STEP_CNT_W = 4;
  localparam int unsigned NUM_ACCEL  = 3;

  localparam logic [31:0] RNG_SEED_DEFAULT = 32'd1;
  localparam logic [31:0] LCG_MUL          = 32'd1664525;
  localparam logic [31:0] LCG_ADD          = 32'd1013904223;
  // 0.5*sqrt(3) in Q0.16
  localparam logic [16:0] HALF_SQRT3_Q16   = 17'd56756;
  localparam int unsigned NOISE_SHIFT      = 39;

  localparam logic [SIGMA_W-1:0] ACCEL_SIGMA_RST = 20'd3277;
  localparam logic [SIGMA_W-1:0] GYRO_SIGMA_RST  = 20'd655;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SIGMA = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_SIGMA  = 3'd7;

  typedef logic [AXIS_W-1:0] axis_t;

  typedef struct packed {
    logic  load_in;
    logic  step;
    logic  second;
    axis_t axis;
    logic  load_out;
  } ibni_cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic out_free;
  } ibni_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/ibni_ctrl.sv
// Sequencer: accepts a sample, issues the twelve draws, waits for drain and hands off the result.
`default_nettype none
module ibni_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_valid_i,
  output logic                s_ready_o,
  input  wire ibni_pkg::ibni_sts_t sts_i,
  output ibni_pkg::ibni_cmd_t cmd_o
);
  import ibni_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAW  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    s_ready_o     = 1'b0;
    cmd_o         = '0;
    cmd_o.axis    = cnt_q[STEP_CNT_W-1:1];
    cmd_o.second  = cnt_q[0];
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = ST_DRAW;
        end
      end
      ST_DRAW: begin
        cmd_o.step = 1'b1;
        if (cnt_q == STEP_CNT_W'(STEPS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // hold until the last axis is written and the output slot is free
        if (sts_i.pipe_empty && sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ibni_dp.sv
// Datapath: config registers, LCG, noise scaling pipeline, saturating sum and output register.
`default_nettype none
module ibni_dp #(
  parameter logic [31:0] RNG_SEED = ibni_pkg::RNG_SEED_DEFAULT
) (
  input  wire                                                   clk_i,
  input  wire                                                   rst_ni,
  input  wire                                                   cfg_we_i,
  input  wire  [ibni_pkg::CFG_IDX_W-1:0]                        cfg_idx_i,
  input  wire  [ibni_pkg::DATA_W-1:0]                           cfg_wdata_i,
  input  wire  [ibni_pkg::NUM_AXES*ibni_pkg::DATA_W-1:0]        in_data_i,
  input  wire                                                   out_ready_i,
  output logic                                                  out_valid_o,
  output logic [ibni_pkg::NUM_AXES*ibni_pkg::DATA_W-1:0]        out_data_o,
  input  wire ibni_pkg::ibni_cmd_t                              cmd_i,
  output ibni_pkg::ibni_sts_t                                   sts_o
);
  import ibni_pkg::*;

  localparam logic [31:0] SEED_INIT = (RNG_SEED == 32'd0) ? 32'd1 : RNG_SEED;

  // Configuration
  logic [NUM_AXES-1:0][DATA_W-1:0] bias_q;
  logic [SIGMA_W-1:0]              accel_sigma_q, gyro_sigma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q        <= '0;
      accel_sigma_q <= ACCEL_SIGMA_RST;
      gyro_sigma_q  <= GYRO_SIGMA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACCEL_SIGMA: accel_sigma_q <= cfg_wdata_i[SIGMA_W-1:0];
        CFG_GYRO_SIGMA:  gyro_sigma_q  <= cfg_wdata_i[SIGMA_W-1:0];
        default:         bias_q[cfg_idx_i] <= cfg_wdata_i;
      endcase
    end
  end

  // Generator
  logic [31:0]        lcg_q, lcg_next;
  logic signed [23:0] draw;
  logic signed [23:0] u1_q, u2_q;

  assign lcg_next = 32'(lcg_q * LCG_MUL) + LCG_ADD;
  // top 24 bits, centred: flip the sign bit
  assign draw     = {~lcg_next[31], lcg_next[30:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= SEED_INIT;
    end else if (cmd_i.step) begin
      lcg_q <= lcg_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (cmd_i.second) begin
        u2_q <= draw;
      end else begin
        u1_q <= draw;
      end
    end
  end

  // Scaling pipeline; a new axis enters before the previous one has left
  logic               v0_q, v1_q, v2_q, v3_q, v4_q;
  axis_t              ax0_q, ax1_q, ax2_q, ax3_q, ax4_q;
  logic signed [24:0] s_q;
  logic signed [44:0] t_q;
  logic signed [60:0] p_q;
  logic signed [22:0] noise_q;

  logic [SIGMA_W-1:0] sigma_sel;
  logic signed [45:0] t_full;
  logic signed [61:0] p_full;
  logic               p_neg;
  logic [60:0]        p_mag, p_rnd;
  logic [21:0]        q_mag;
  logic signed [22:0] noise_d;

  assign sigma_sel = (ax1_q < AXIS_W'(NUM_ACCEL)) ? accel_sigma_q : gyro_sigma_q;
  assign t_full    = s_q * $signed({1'b0, sigma_sel});
  assign p_full    = t_q * $signed(HALF_SQRT3_Q16);
  assign p_neg     = p_q[60];
  assign p_mag     = p_neg ? 61'(-p_q) : 61'(p_q);
  assign p_rnd     = p_mag + (61'd1 << (NOISE_SHIFT - 1));
  assign q_mag     = p_rnd[60:NOISE_SHIFT];
  assign noise_d   = p_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.step && cmd_i.second;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax0_q   <= cmd_i.axis;
    ax1_q   <= ax0_q;
    ax2_q   <= ax1_q;
    ax3_q   <= ax2_q;
    ax4_q   <= ax3_q;
    s_q     <= 25'(u1_q) + 25'(u2_q);
    t_q     <= t_full[44:0];
    p_q     <= p_full[60:0];
    noise_q <= noise_d;
  end

  // Sample registers, overwritten in place by the measured values
  logic [NUM_AXES-1:0][DATA_W-1:0] smp_q;
  logic signed [33:0]              sum;
  logic [DATA_W-1:0]               sat;

  assign sum = 34'($signed(smp_q[ax4_q])) + 34'($signed(bias_q[ax4_q])) + 34'(noise_q);

  always_comb begin
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      sat = sum[31:0];
    end else if (sum[33]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      smp_q <= in_data_i;
    end else if (v4_q) begin
      smp_q[ax4_q] <= sat;
    end
  end

  // Output register
  logic                            out_vld_q;
  logic [NUM_AXES-1:0][DATA_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= smp_q;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_data_o       = out_q;
  assign sts_o.pipe_empty = !(v0_q || v1_q || v2_q || v3_q || v4_q);
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

endmodule
`default_nettype wire

>>> rtl/core/imu_bias_noise_injector.sv
// Each request runs twelve chained LCG steps through one multiplier, a five-stage noise
// scaling and saturation pipeline and a handoff to the output register, then returns to
// idle; a new request is accepted only after the previous result has been handed off.
// A finished result waits in its output register while the next request is accepted.
// Reset (rst_ni low, asynchronous): biases clear, sigmas take 0.05 and 0.01, generator
// takes RNG_SEED (one when zero), no request or result is pending.
`default_nettype none
module imu_bias_noise_injector #(
  parameter logic [31:0] RNG_SEED = ibni_pkg::RNG_SEED_DEFAULT
) (
  input  wire                                            clk_i,
  input  wire                                            rst_ni,
  input  wire                                            cfg_we_i,
  input  wire  [ibni_pkg::CFG_IDX_W-1:0]                 cfg_idx_i,
  input  wire  [ibni_pkg::DATA_W-1:0]                    cfg_wdata_i,
  input  wire                                            s_axis_tvalid,
  output logic                                           s_axis_tready,
  // true_accel_x, true_accel_y, true_accel_z, true_rate_x, true_rate_y, true_rate_z
  input  wire  [ibni_pkg::NUM_AXES*ibni_pkg::DATA_W-1:0] s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  wire                                            m_axis_tready,
  // meas_accel_x, meas_accel_y, meas_accel_z, meas_rate_x, meas_rate_y, meas_rate_z
  output logic [ibni_pkg::NUM_AXES*ibni_pkg::DATA_W-1:0] m_axis_tdata
);
  import ibni_pkg::*;

  ibni_cmd_t cmd;
  ibni_sts_t sts;

  ibni_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ibni_dp #(
    .RNG_SEED (RNG_SEED)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

>>> sim/imu_bias_noise_injector_test.sv
// Self-checking stream bench for the IMU bias and noise injector, with an in-bench noise predictor.
module imu_bias_noise_injector_test;
  import ibni_pkg::*;

  localparam int          NUM_REGS       = 8;
  localparam int          SAMPLE_W       = NUM_AXES * DATA_W;
  localparam int          DRAIN_CYCLES   = 30;
  localparam int          HOLD_CYCLES    = 600;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam logic [31:0] SAT_HI         = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_LO         = 32'h8000_0000;
  localparam longint      Q16_MAX        = 64'sh7FFF_FFFF;
  localparam longint      Q16_MIN        = -64'sh8000_0000;
  localparam logic [31:0] SIGMA_TOP      = 32'd655360;
  localparam logic [31:0] SIGMA_FULL     = 32'h000F_FFFF;

  typedef logic [SAMPLE_W-1:0] imu_vec_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [DATA_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  imu_vec_t             s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  imu_vec_t             m_axis_tdata;

  // Predictor copy of the generator and the registers
  logic [31:0]        noise_lcg;
  logic [DATA_W-1:0]  bias_reg [NUM_AXES];
  logic [SIGMA_W-1:0] accel_sigma_reg;
  logic [SIGMA_W-1:0] gyro_sigma_reg;

  logic [31:0] reg_vals [NUM_REGS];
  imu_vec_t    meas_queue [$];
  int          errors      = 0;
  int          stall_left  = 0;
  int          idle_cycles = 0;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;
  bit          stall_request = 1'b0;

  string field_name [NUM_AXES] = '{"meas_accel_x", "meas_accel_y", "meas_accel_z",
                                   "meas_rate_x", "meas_rate_y", "meas_rate_z"};

  imu_bias_noise_injector #(
    .RNG_SEED(RNG_SEED_DEFAULT)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    // true_accel_x, true_accel_y, true_accel_z, true_rate_x, true_rate_y, true_rate_z
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    // meas_accel_x, meas_accel_y, meas_accel_z, meas_rate_x, meas_rate_y, meas_rate_z
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Two generator steps, triangular noise, bias, then clamp to Q16.16
  function automatic logic [DATA_W-1:0] corrupt_axis(input logic [DATA_W-1:0] truth,
                                                     input logic [DATA_W-1:0] bias,
                                                     input logic [SIGMA_W-1:0] sigma);
    longint tri_sum;
    longint prod;
    longint mag;
    longint noise;
    longint total;
    tri_sum = 0;
    repeat (2) begin
      noise_lcg = noise_lcg * LCG_MUL + LCG_ADD;
      tri_sum += longint'({40'd0, noise_lcg[31:8]}) - 64'sd8388608;
    end
    prod  = tri_sum * longint'({44'd0, sigma}) * longint'({47'd0, HALF_SQRT3_Q16});
    mag   = (prod < 0) ? -prod : prod;
    // round half away from zero
    noise = (mag + (64'sd1 <<< (NOISE_SHIFT - 1))) >>> NOISE_SHIFT;
    if (prod < 0) noise = -noise;
    total = longint'($signed(truth)) + longint'($signed(bias)) + noise;
    if (total > Q16_MAX) total = Q16_MAX;
    if (total < Q16_MIN) total = Q16_MIN;
    return total[DATA_W-1:0];
  endfunction

  function automatic imu_vec_t predict_measurement(input imu_vec_t truth);
    imu_vec_t meas;
    for (int a = 0; a < NUM_AXES; a++) begin
      meas[a*DATA_W +: DATA_W] = corrupt_axis(truth[a*DATA_W +: DATA_W], bias_reg[a],
                                              (a < NUM_ACCEL) ? accel_sigma_reg : gyro_sigma_reg);
    end
    return meas;
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(9))
      0:       return SAT_HI;
      1:       return SAT_LO;
      2:       return '0;
      3:       return SAT_HI - $urandom_range(0, 32'h000F_FFFF);
      4:       return SAT_LO + $urandom_range(0, 32'h000F_FFFF);
      5, 6:    return $urandom;
      default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
    endcase
  endfunction

  function automatic imu_vec_t rand_sample();
    imu_vec_t v;
    for (int a = 0; a < NUM_AXES; a++) v[a*DATA_W +: DATA_W] = rand_q16();
    return v;
  endfunction

  function automatic logic [31:0] rand_sigma_word();
    logic [31:0] w;
    case ($urandom_range(7))
      0:       w = '0;
      1:       w = SIGMA_TOP;
      2:       w = SIGMA_FULL;
      3:       w = $urandom_range(0, 8192);
      default: w = $urandom_range(0, SIGMA_TOP);
    endcase
    // junk above the register width must be dropped
    if ($urandom_range(3) == 0) w |= $urandom & 32'hFFF0_0000;
    return w;
  endfunction

  // Write all registers from reg_vals, one per cycle, and mirror them in the predictor
  task automatic program_config();
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(r);
      cfg_wdata_i <= reg_vals[r];
      if (r == CFG_ACCEL_SIGMA) accel_sigma_reg = reg_vals[r][SIGMA_W-1:0];
      else if (r == CFG_GYRO_SIGMA) gyro_sigma_reg = reg_vals[r][SIGMA_W-1:0];
      else bias_reg[r] = reg_vals[r];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] bias, input logic [31:0] a_sigma,
                            input logic [31:0] g_sigma);
    for (int r = 0; r < NUM_REGS; r++) reg_vals[r] = bias;
    reg_vals[CFG_ACCEL_SIGMA] = a_sigma;
    reg_vals[CFG_GYRO_SIGMA]  = g_sigma;
    program_config();
  endtask

  task automatic send_sample(input imu_vec_t truth);
    if (src_idle_en && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= truth;
    do @(posedge clk_i); while (!s_axis_tready);
    meas_queue.push_back(predict_measurement(truth));
  endtask

  // Drop valid, wait for every outstanding request, then let the pipeline settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (meas_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_sample('0);
    send_sample({NUM_AXES{SAT_HI}});
    send_sample({NUM_AXES{SAT_LO}});
    send_sample({3{SAT_LO, SAT_HI}});
    drain_results();
  endtask

  task automatic test_saturation();
    // widest sigma with junk above the width, biases at the rails
    set_config(SAT_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample({NUM_AXES{SAT_HI}});
    send_sample({NUM_AXES{SAT_LO}});
    send_sample('0);
    drain_results();
    set_config(SAT_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_sample({NUM_AXES{SAT_LO}});
    send_sample({NUM_AXES{SAT_HI}});
    send_sample('0);
    drain_results();
  endtask

  task automatic test_sigma_limits();
    // zero sigma leaves only the bias
    set_config(32'h0001_8000, '0, '0);
    send_sample(rand_sample());
    send_sample(rand_sample());
    drain_results();
    set_config('0, SIGMA_TOP, SIGMA_TOP);
    repeat (3) send_sample(rand_sample());
    drain_results();
    set_config(32'hFFFF_0000, SIGMA_FULL, '0);
    repeat (3) send_sample(rand_sample());
    drain_results();
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        if (r == CFG_ACCEL_SIGMA || r == CFG_GYRO_SIGMA) reg_vals[r] = rand_sigma_word();
        else reg_vals[r] = rand_q16();
      end
      program_config();
      // hold one phase at full rate on both sides
      src_idle_en = (p != 1);
      snk_idle_en = (p != 1);
      repeat (per_phase) send_sample(rand_sample());
      drain_results();
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    stall_request <= 1'b1;
    repeat (150) send_sample(rand_sample());
    drain_results();
  endtask

  initial begin
    for (int a = 0; a < NUM_AXES; a++) bias_reg[a] = '0;
    accel_sigma_reg = ACCEL_SIGMA_RST;
    gyro_sigma_reg  = GYRO_SIGMA_RST;
    noise_lcg       = (RNG_SEED_DEFAULT == '0) ? 32'd1 : RNG_SEED_DEFAULT;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_saturation();
    test_sigma_limits();
    test_random_traffic(6, 300);
    test_output_stall();
    if (errors == 0 && meas_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: check each accepted result, drive tready with random holds
  always @(posedge clk_i) begin
    imu_vec_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (meas_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = meas_queue.pop_front();
        for (int a = 0; a < NUM_AXES; a++) begin
          if (m_axis_tdata[a*DATA_W +: DATA_W] !== want[a*DATA_W +: DATA_W]) begin
            $display("%0t: %s expected %h got %h", $time, field_name[a],
                     want[a*DATA_W +: DATA_W], m_axis_tdata[a*DATA_W +: DATA_W]);
            errors++;
          end
        end
      end
    end
    if (stall_request) begin
      stall_left = HOLD_CYCLES;
      stall_request <= 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(snk_idle_en && $urandom_range(99) < 26);
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/core/ibni_pkg.sv
rtl/core/ibni_ctrl.sv
rtl/core/ibni_dp.sv
rtl/core/imu_bias_noise_injector.sv
sim/imu_bias_noise_injector_test.sv
